/* sv/fpv_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types, coefficients and the quarter-wave sine table builder.
package fpv_pkg;

  // Series size and sine table resolution.
  localparam int HARMONICS  = 15;
  localparam int TABLE_BITS = 10;
  localparam int MAX_HARM   = 32;

  localparam int ROM_N  = 1 << TABLE_BITS;
  localparam int ROM_W  = 16;
  localparam int ADDR_W = TABLE_BITS + 1;
  localparam int ANG_W  = TABLE_BITS + 2;
  localparam int MAG_W  = ROM_W + 1;

  localparam int COEF_W   = 17;
  localparam int PROD_W   = COEF_W + MAG_W;
  localparam int SUM_W    = 40;
  localparam int GRP_SIZE = 4;
  localparam int GROUPS   = (HARMONICS + GRP_SIZE - 1) / GRP_SIZE;

  localparam int OFFSET_SHIFT = 13;
  localparam int DIFF_W       = 47;
  localparam int DMAG_W       = DIFF_W - 1;
  localparam int GAIN_HALF    = 16;
  localparam int PART_W       = DMAG_W + GAIN_HALF;
  localparam int SPEED_SHIFT  = 17;
  localparam int SPEED_W      = PART_W + 1 - SPEED_SHIFT;

  localparam int NRM_W     = 16;
  localparam int VPROD_W   = SPEED_W + NRM_W;
  localparam int VEL_SHIFT = 23;
  localparam int VMAG_W    = VPROD_W - VEL_SHIFT;
  localparam int VEL_W     = 32;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  // Pipeline stages, numbered from the input side.
  localparam int STG_PHASE = 1;
  localparam int STG_ANGLE = 2;
  localparam int STG_ROM   = 3;
  localparam int STG_MUL   = 4;
  localparam int STG_LANE  = 5;
  localparam int STG_GROUP = 6;
  localparam int STG_DIFF  = 7;
  localparam int STG_ABS   = 8;
  localparam int STG_GAIN  = 9;
  localparam int STG_SPEED = 10;
  localparam int STG_NMUL  = 11;
  localparam int STG_OUT   = 12;
  localparam int NSTG      = STG_OUT;

  localparam logic signed [31:0] FLOW_OFFSET_RST   = 32'sd0;
  localparam logic [31:0]        CYCLE_RATE_RST    = 32'd65536;
  localparam logic [31:0]        VELOCITY_GAIN_RST = 32'd0;

  localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef logic [NSTG:1] stg_t;
  typedef logic [2:0][NRM_W-1:0] nrm_t;
  typedef logic [2:0][VEL_W-1:0] vel_t;
  typedef logic [ROM_N:0][ROM_W-1:0] rom_t;

  typedef struct packed {
    logic signed [31:0] flow_offset;
    logic [31:0]        cycle_rate;
    logic [31:0]        velocity_gain;
  } cfg_t;

  // Register indexes; index three is unmapped and ignores writes.
  typedef enum logic [1:0] {
    REG_FLOW_OFFSET   = 2'd0,
    REG_CYCLE_RATE    = 2'd1,
    REG_VELOCITY_GAIN = 2'd2,
    REG_SPARE         = 2'd3
  } reg_idx_t;

  // Q2.14 series coefficients; harmonics above the fifteenth are zero.
  localparam int COS_COEF [MAX_HARM] = '{
    46463, -18012, 11593, 8010, -4840, 1877, -6064, 3869,
    -765, 1323, 90, -1267, 671, -624, 634, 0,
    0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };
  localparam int SIN_COEF [MAX_HARM] = '{
    18574, -14076, -17186, 11728, -1111, 3726, -2269, -2504,
    1350, -1154, 1990, -581, -244, 243, -866, 0,
    0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // Shift-and-subtract quotient used by the table builder.
  function automatic logic [63:0] long_quot(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Builds the quarter-wave table at elaboration from a Q30 Taylor series,
  // rounded half up to Q15 magnitudes.
  function automatic rom_t build_qrom();
    rom_t        rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] v;
    logic [63:0] dv;
    longint      acc;
    rom = '0;
    for (int i = 0; i <= ROM_N; i++) begin
      x    = (PI_HALF_Q30 * 64'(i)) >> TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = 0;
      for (int n = 0; n < 12; n++) begin
        if ((n & 1) != 0) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
        dv   = 64'((2 * n + 2) * (2 * n + 3));
        term = long_quot((term * x2) >> 30, dv);
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (64'(acc) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
        v = 64'd32768;
      end
      rom[i] = ROM_W'(v);
    end
    return rom;
  endfunction

endpackage

/* sv/fpv_cfg.sv */
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module fpv_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpv_pkg::CFG_AW-1:0]    paddr,
  input  logic [fpv_pkg::CFG_DW-1:0]    pwdata,
  output logic [fpv_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output fpv_pkg::cfg_t                 cfg
);
  import fpv_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (idx)
        REG_FLOW_OFFSET: begin
          cfg_nxt.flow_offset = $signed(pwdata);
        end
        REG_CYCLE_RATE: begin
          cfg_nxt.cycle_rate = pwdata;
        end
        REG_VELOCITY_GAIN: begin
          cfg_nxt.velocity_gain = pwdata;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FLOW_OFFSET: begin
        prdata = cfg_r.flow_offset;
      end
      REG_CYCLE_RATE: begin
        prdata = cfg_r.cycle_rate;
      end
      REG_VELOCITY_GAIN: begin
        prdata = cfg_r.velocity_gain;
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flow_offset   <= FLOW_OFFSET_RST;
      cfg_r.cycle_rate    <= CYCLE_RATE_RST;
      cfg_r.velocity_gain <= VELOCITY_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

/* sv/fpv_flow.sv */
`timescale 1ns / 1ps
// Valid bits and per-stage load enables for the velocity pipeline.
module fpv_flow (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output fpv_pkg::stg_t en
);
  import fpv_pkg::*;

  stg_t valid_r;
  stg_t valid_nxt;
  stg_t rdy;
  stg_t prev;

  // A stage can load when the output drains or some stage at or after it is empty,
  // so bubbles are squeezed out while the output is stalled.
  always_comb begin
    for (int s = 1; s <= NSTG; s++) begin
      rdy[s] = out_ready | ~(&(valid_r | stg_t'((1 << (s - 1)) - 1)));
    end
    prev      = {valid_r[NSTG-1:1], in_valid};
    en        = rdy & prev;
    valid_nxt = (rdy & prev) | (~rdy & valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = valid_r[NSTG];

  a_room_means_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> in_ready)
    else $error("pipeline has an empty stage but refuses input");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> $countones(valid_r) == $past($countones(valid_r)) + 1)
    else $error("accepted word not held in the pipeline");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && in_ready) && out_valid && out_ready)
    |=> $countones(valid_r) + 1 == $past($countones(valid_r)))
    else $error("delivered word not removed from the pipeline");

endmodule

/* sv/fpv_series.sv */
`timescale 1ns / 1ps
// Phase, harmonic lanes with sine tables, adder tree and offset difference.
module fpv_series (
  input  logic                                clk,
  input  fpv_pkg::stg_t                       en,
  input  fpv_pkg::cfg_t                       cfg,
  input  logic [31:0]                         time_value,
  output logic signed [fpv_pkg::DIFF_W-1:0]   diff
);
  import fpv_pkg::*;

  localparam rom_t QROM = build_qrom();

  logic [31:0]              phase_r;
  logic signed [SUM_W-1:0]  lane_sum [HARMONICS];
  logic signed [SUM_W-1:0]  grp_sum [GROUPS];
  logic signed [SUM_W-1:0]  series;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [DIFF_W-1:0] diff_r;

  // Only the low word of the product is the cycle fraction.
  always_ff @(posedge clk) begin
    if (en[STG_PHASE]) begin
      phase_r <= 32'(time_value * cfg.cycle_rate);
    end
  end

  function automatic logic [ADDR_W-1:0] qaddr(input logic [ANG_W-1:0] p);
    logic [ADDR_W-1:0] j;
    j = ADDR_W'(p[TABLE_BITS-1:0]);
    return p[TABLE_BITS] ? ADDR_W'(ROM_N) - j : j;
  endfunction

  for (genvar k = 0; k < HARMONICS; k++) begin : g_lane
    localparam rom_t LROM = QROM;
    localparam logic signed [COEF_W-1:0] COS_K = COEF_W'(COS_COEF[k]);
    localparam logic signed [COEF_W-1:0] SIN_K = COEF_W'(SIN_COEF[k]);

    logic [31:0]              ang;
    logic [ANG_W-1:0]         p_sin;
    logic [ANG_W-1:0]         p_cos;
    logic [ADDR_W-1:0]        sin_addr_r;
    logic [ADDR_W-1:0]        cos_addr_r;
    logic                     sin_neg_a_r;
    logic                     cos_neg_a_r;
    logic [ROM_W-1:0]         sin_mag_r;
    logic [ROM_W-1:0]         cos_mag_r;
    logic                     sin_neg_m_r;
    logic                     cos_neg_m_r;
    logic signed [MAG_W-1:0]  sin_val;
    logic signed [MAG_W-1:0]  cos_val;
    logic signed [PROD_W-1:0] sin_prod_r;
    logic signed [PROD_W-1:0] cos_prod_r;
    logic signed [SUM_W-1:0]  lane_r;

    // Harmonic angle; cosine is the same angle a quarter turn ahead.
    assign ang   = 32'(phase_r * 32'(k + 1));
    assign p_sin = ang[31 -: ANG_W];
    assign p_cos = p_sin + ANG_W'(ROM_N);

    always_ff @(posedge clk) begin
      if (en[STG_ANGLE]) begin
        sin_addr_r  <= qaddr(p_sin);
        cos_addr_r  <= qaddr(p_cos);
        sin_neg_a_r <= p_sin[ANG_W-1];
        cos_neg_a_r <= p_cos[ANG_W-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[STG_ROM]) begin
        sin_mag_r   <= LROM[sin_addr_r];
        cos_mag_r   <= LROM[cos_addr_r];
        sin_neg_m_r <= sin_neg_a_r;
        cos_neg_m_r <= cos_neg_a_r;
      end
    end

    assign sin_val = sin_neg_m_r ? -$signed({1'b0, sin_mag_r}) : $signed({1'b0, sin_mag_r});
    assign cos_val = cos_neg_m_r ? -$signed({1'b0, cos_mag_r}) : $signed({1'b0, cos_mag_r});

    always_ff @(posedge clk) begin
      if (en[STG_MUL]) begin
        sin_prod_r <= PROD_W'(SIN_K) * PROD_W'(sin_val);
        cos_prod_r <= PROD_W'(COS_K) * PROD_W'(cos_val);
      end
    end

    always_ff @(posedge clk) begin
      if (en[STG_LANE]) begin
        lane_r <= SUM_W'(sin_prod_r) + SUM_W'(cos_prod_r);
      end
    end

    assign lane_sum[k] = lane_r;
  end

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    logic signed [SUM_W-1:0] grp_nxt;
    logic signed [SUM_W-1:0] grp_r;

    always_comb begin
      grp_nxt = '0;
      for (int i = g * GRP_SIZE; i < (g + 1) * GRP_SIZE && i < HARMONICS; i++) begin
        grp_nxt = grp_nxt + lane_sum[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en[STG_GROUP]) begin
        grp_r <= grp_nxt;
      end
    end

    assign grp_sum[g] = grp_r;
  end

  always_comb begin
    series = '0;
    for (int g = 0; g < GROUPS; g++) begin
      series = series + grp_sum[g];
    end
    diff_nxt = (DIFF_W'(cfg.flow_offset) <<< OFFSET_SHIFT) - DIFF_W'(series);
  end

  always_ff @(posedge clk) begin
    if (en[STG_DIFF]) begin
      diff_r <= diff_nxt;
    end
  end

  assign diff = diff_r;

endmodule

/* sv/fpv_scale.sv */
`timescale 1ns / 1ps
// Gain scaling of the difference and projection onto the face normal with saturation.
module fpv_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fpv_pkg::stg_t                     en,
  input  fpv_pkg::cfg_t                     cfg,
  input  fpv_pkg::nrm_t                     normal,
  input  logic signed [fpv_pkg::DIFF_W-1:0] diff,
  output fpv_pkg::vel_t                     vel
);
  import fpv_pkg::*;

  nrm_t                     nrm_r [STG_PHASE:STG_SPEED];
  logic [DMAG_W-1:0]        dmag_r;
  logic                     sign_abs_r;
  logic                     sign_gain_r;
  logic                     sign_speed_r;
  logic [PART_W-1:0]        hi_r;
  logic [PART_W-1:0]        lo_r;
  logic [PART_W:0]          speed_sum;
  logic [SPEED_W-1:0]       speed_r;
  logic signed [NRM_W-1:0]  n_s [3];
  logic [NRM_W-1:0]         nmag [3];
  logic [VPROD_W-1:0]       vp_r [3];
  logic [2:0]               vneg_r;
  logic [VMAG_W-1:0]        mag [3];
  vel_t                     vel_nxt;
  vel_t                     vel_r;

  // The normal rides alongside the series, absolute, gain and speed stages.
  always_ff @(posedge clk) begin
    if (en[STG_PHASE]) begin
      nrm_r[STG_PHASE] <= normal;
    end
    for (int s = STG_PHASE + 1; s <= STG_SPEED; s++) begin
      if (en[s]) begin
        nrm_r[s] <= nrm_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_ABS]) begin
      sign_abs_r <= diff[DIFF_W-1];
      dmag_r     <= DMAG_W'(diff[DIFF_W-1] ? -diff : diff);
    end
  end

  // The gain is split in halves so each multiplier stays narrow.
  always_ff @(posedge clk) begin
    if (en[STG_GAIN]) begin
      sign_gain_r <= sign_abs_r;
      hi_r        <= PART_W'(dmag_r) * PART_W'(cfg.velocity_gain[31:GAIN_HALF]);
      lo_r        <= PART_W'(dmag_r) * PART_W'(cfg.velocity_gain[GAIN_HALF-1:0]);
    end
  end

  assign speed_sum = (PART_W + 1)'(hi_r) + (PART_W + 1)'(lo_r >> GAIN_HALF);

  always_ff @(posedge clk) begin
    if (en[STG_SPEED]) begin
      sign_speed_r <= sign_gain_r;
      speed_r      <= SPEED_W'(speed_sum >> SPEED_SHIFT);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      n_s[c]  = $signed(nrm_r[STG_SPEED][c]);
      nmag[c] = n_s[c][NRM_W-1] ? NRM_W'(-n_s[c]) : NRM_W'(n_s[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_NMUL]) begin
      for (int c = 0; c < 3; c++) begin
        vp_r[c]   <= VPROD_W'(speed_r) * VPROD_W'(nmag[c]);
        vneg_r[c] <= sign_speed_r ^ n_s[c][NRM_W-1];
      end
    end
  end

  // Magnitudes at or beyond 2^31 clamp to the signed limits.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = VMAG_W'(vp_r[c] >> VEL_SHIFT);
      if (mag[c][VMAG_W-1:VEL_W-1] != '0) begin
        vel_nxt[c] = vneg_r[c] ? VEL_MIN : VEL_MAX;
      end else if (vneg_r[c]) begin
        vel_nxt[c] = VEL_W'(-mag[c]);
      end else begin
        vel_nxt[c] = VEL_W'(mag[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      vel_r <= vel_nxt;
    end
  end

  assign vel = vel_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en[STG_OUT] |=> $stable(vel_r))
    else $error("output word changed without a load");

  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (en[STG_SPEED] && cfg.velocity_gain == '0) |=> speed_r == '0)
    else $error("nonzero speed with zero gain");

  a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (en[STG_OUT] && !vneg_r[0]) |=> !vel_r[0][VEL_W-1])
    else $error("positive x velocity came out negative");

endmodule

/* sv/fourier_pulsatile_velocity.sv */
`timescale 1ns / 1ps
// Pulsatile inlet velocity: Fourier flow waveform scaled along a face normal.
//
//  Channel | Ports                     | Word layout, low bit first
//  --------+---------------------------+---------------------------------------------
//  input   | in_tvalid/tready/tdata    | time_value[31:0] normal_x normal_y normal_z
//  result  | out_tvalid/tready/tdata   | velocity_x[31:0] velocity_y velocity_z
//  config  | cfg_psel..cfg_pready      | 0x0 flow_offset, 0x4 cycle_rate, 0x8 gain
//
// One word per cycle unless a stall fills all twelve stages; there is no feedback loop.
// An accepted word moves stage by stage from the phase register to the output register.
// Reset is synchronous; it clears the valid bits and loads the config defaults.
// A stalled output holds its word; upstream stages keep loading until every stage is full.
module fourier_pulsatile_velocity (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // time_value[31:0], normal_x[47:32], normal_y[63:48], normal_z[79:64]
  input  logic [fpv_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // velocity_x[31:0], velocity_y[63:32], velocity_z[95:64]
  output logic [fpv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [fpv_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [fpv_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [fpv_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                               cfg_pready
);
  import fpv_pkg::*;

  cfg_t                     cfg;
  stg_t                     en;
  logic signed [DIFF_W-1:0] diff;
  vel_t                     vel;

  fpv_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  fpv_flow u_flow (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .en        (en)
  );

  fpv_series u_series (
    .clk        (clk),
    .en         (en),
    .cfg        (cfg),
    .time_value (in_tdata[31:0]),
    .diff       (diff)
  );

  fpv_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .cfg    (cfg),
    .normal (nrm_t'(in_tdata[IN_TDATA_W-1:32])),
    .diff   (diff),
    .vel    (vel)
  );

  assign out_tdata = vel;

endmodule
